>>> design/ldl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldl_pkg: shared types and constants
// Opcodes, status codes, field widths and the cell command word used by the
// lazy deletion list table.
// ----------------------------------------------------------------------------
package ldl_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int VALUE_W_DEF = 32;

  // fixed field widths of the channels
  localparam int OPC_W  = 2;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 4;
  localparam int STAT_W = 3;
  localparam int LEN_W  = 5;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_RANGE     = 3'd4
  } status_t;

  // what every cell of the chain does in a cycle
  typedef enum logic [2:0] {
    CO_HOLD,
    CO_PUSH,    // take the left neighbour's entry
    CO_ROTATE,  // take the right neighbour's entry
    CO_PURGE,   // drop marked entry, clear mark
    CO_SORT     // odd-even exchange of holes towards the back
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;  // which pairs exchange during CO_SORT
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_PURGE,
    S_SORT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> design/ldl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldl_if: channel interfaces
// Valid/ready channels for the command word and the result word.
// ----------------------------------------------------------------------------
interface ldl_in_if;
  import ldl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OPC_W-1:0]         opcode;
  logic signed [VAL_W-1:0]  value;
  logic [POS_W-1:0]         position;
  modport source (output valid, opcode, value, position, input ready);
  modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface ldl_out_if;
  import ldl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic                     compacted;
  logic [LEN_W-1:0]         list_length;
  logic [LEN_W-1:0]         marked_count;
  logic signed [VAL_W-1:0]  read_value;
  logic                     read_marked;
  modport source (output valid, status, compacted, list_length, marked_count,
                  read_value, read_marked, input ready);
  modport sink   (input valid, status, compacted, list_length, marked_count,
                  read_value, read_marked, output ready);
endinterface
`default_nettype wire

>>> design/ldl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldl_cell: one list slot
// Holds a value, its deleted mark and an occupied flag; moves to or from its
// neighbours as the chain command says.
// ----------------------------------------------------------------------------
module ldl_cell #(
  parameter int VALUE_W = 32,
  parameter int IDX     = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ldl_pkg::cell_cmd_t cmd,
  input  wire logic [VALUE_W-1:0] left_value,
  input  wire logic               left_mark,
  input  wire logic               left_occ,
  input  wire logic [VALUE_W-1:0] right_value,
  input  wire logic               right_mark,
  input  wire logic               right_occ,
  output logic [VALUE_W-1:0]      value,
  output logic                    mark,
  output logic                    occ
);
  import ldl_pkg::*;

  localparam logic PAR = 1'(IDX % 2);

  logic [VALUE_W-1:0] value_r, value_nxt;
  logic               mark_r, mark_nxt;
  logic               occ_r, occ_nxt;

  always_comb begin
    value_nxt = value_r;
    mark_nxt  = mark_r;
    occ_nxt   = occ_r;
    unique case (cmd.op)
      CO_HOLD: ;
      CO_PUSH: begin
        value_nxt = left_value;
        mark_nxt  = left_mark;
        occ_nxt   = left_occ;
      end
      CO_ROTATE: begin
        value_nxt = right_value;
        mark_nxt  = right_mark;
        occ_nxt   = right_occ;
      end
      CO_PURGE: begin
        occ_nxt  = occ_r & ~mark_r;
        mark_nxt = 1'b0;
      end
      CO_SORT: begin
        // left member of a pair pulls a live entry into its hole,
        // right member gives it up
        if (PAR == cmd.phase) begin
          if (!occ_r && right_occ) begin
            value_nxt = right_value;
            mark_nxt  = right_mark;
            occ_nxt   = right_occ;
          end
        end else if (!left_occ && occ_r) begin
          value_nxt = left_value;
          mark_nxt  = left_mark;
          occ_nxt   = left_occ;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= 1'b0;
      occ_r  <= 1'b0;
    end else begin
      mark_r <= mark_nxt;
      occ_r  <= occ_nxt;
    end
  end

  assign value = value_r;
  assign mark  = mark_r;
  assign occ   = occ_r;

endmodule
`default_nettype wire

>>> design/ldl_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldl_chain: row of list cells
// Cell 0 is the list front; the head input feeds it, the tail input feeds
// the last cell.
// ----------------------------------------------------------------------------
module ldl_chain #(
  parameter int DEPTH   = 16,
  parameter int VALUE_W = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ldl_pkg::cell_cmd_t cmd,
  input  wire logic [VALUE_W-1:0] head_in_value,
  input  wire logic               head_in_mark,
  input  wire logic               head_in_occ,
  input  wire logic [VALUE_W-1:0] tail_in_value,
  input  wire logic               tail_in_mark,
  input  wire logic               tail_in_occ,
  output logic [VALUE_W-1:0]      head_value,
  output logic                    head_mark,
  output logic                    head_occ
);
  import ldl_pkg::*;

  logic [VALUE_W-1:0] val_a  [DEPTH];
  logic               mark_a [DEPTH];
  logic               occ_a  [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_W-1:0] lv, rv;
    logic               lm, lo, rm, ro;

    if (g == 0) begin : g_head
      assign lv = head_in_value;
      assign lm = head_in_mark;
      assign lo = head_in_occ;
    end else begin : g_mid_l
      assign lv = val_a[g-1];
      assign lm = mark_a[g-1];
      assign lo = occ_a[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign rv = tail_in_value;
      assign rm = tail_in_mark;
      assign ro = tail_in_occ;
    end else begin : g_mid_r
      assign rv = val_a[g+1];
      assign rm = mark_a[g+1];
      assign ro = occ_a[g+1];
    end

    ldl_cell #(
      .VALUE_W (VALUE_W),
      .IDX     (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_value  (lv),
      .left_mark   (lm),
      .left_occ    (lo),
      .right_value (rv),
      .right_mark  (rm),
      .right_occ   (ro),
      .value       (val_a[g]),
      .mark        (mark_a[g]),
      .occ         (occ_a[g])
    );
  end

  assign head_value = val_a[0];
  assign head_mark  = mark_a[0];
  assign head_occ   = occ_a[0];

endmodule
`default_nettype wire

>>> design/lazy_deletion_list_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lazy_deletion_list_table_top: ordered list with lazy deletion
// Command words come in on in_ch, one result word per command leaves on out_ch.
// ----------------------------------------------------------------------------
// Usage notes
//  - One command is worked at a time; in_ch.ready is high only while idle.
//  - Insert: the cell row shifts once towards the back, then the result is
//    written. A full table goes straight to the result.
//  - Delete and read: the whole row is rotated once past the front cell,
//    each entry compared or captured at the front.
//  - A delete that trips compaction adds a purge step and DEPTH rounds of
//    odd-even exchange that push holes to the back.
//  - Empty list, out-of-range read and the no-op go straight to the result.
//  - The result sits in an output register: the next command is taken while
//    an earlier word still waits; if the receiver stalls with a word held and
//    another is finished, the block waits in its done state.
//  - Synchronous active-low reset empties the list and clears all marks;
//    stored values are not cleared, cells past the length are never read.
// ----------------------------------------------------------------------------
module lazy_deletion_list_table_top #(
  parameter int DEPTH   = ldl_pkg::DEPTH_DEF,
  parameter int VALUE_W = ldl_pkg::VALUE_W_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ldl_in_if.sink    in_ch,
  ldl_out_if.source out_ch
);
  import ldl_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);    // length counter
  localparam int SW   = $clog2(DEPTH);        // step counter
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // control
  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] marked_r, marked_nxt;
  logic          out_valid_r, out_valid_nxt;
  // working registers
  opcode_t            opc_r, opc_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  logic               found_r, found_nxt;
  status_t            status_r, status_nxt;
  logic               compacted_r, compacted_nxt;
  logic [VAL_W-1:0]   rval_r, rval_nxt;
  logic               rmark_r, rmark_nxt;
  // output word
  logic [STAT_W-1:0] o_status_r, o_status_nxt;
  logic              o_comp_r, o_comp_nxt;
  logic [LEN_W-1:0]  o_len_r, o_len_nxt;
  logic [LEN_W-1:0]  o_mark_r, o_mark_nxt;
  logic [VAL_W-1:0]  o_rval_r, o_rval_nxt;
  logic              o_rmark_r, o_rmark_nxt;

  // chain hookup
  cell_cmd_t          cmd;
  logic [VALUE_W-1:0] head_in_value, tail_in_value, head_value;
  logic               head_in_mark, head_in_occ, tail_in_mark, tail_in_occ;
  logic               head_mark, head_occ;

  logic accept, hit, last_step, out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign last_step   = (step_r == SW'(DEPTH - 1));
  assign out_free    = !out_valid_r || out_ch.ready;

  // first live match passing the front cell during a delete scan
  assign hit = (opc_r == OP_DELETE) && !found_r && head_occ && !head_mark &&
               (head_value == key_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    marked_nxt    = marked_r;
    out_valid_nxt = out_valid_r;
    opc_nxt       = opc_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    compacted_nxt = compacted_r;
    rval_nxt      = rval_r;
    rmark_nxt     = rmark_r;
    o_status_nxt  = o_status_r;
    o_comp_nxt    = o_comp_r;
    o_len_nxt     = o_len_r;
    o_mark_nxt    = o_mark_r;
    o_rval_nxt    = o_rval_r;
    o_rmark_nxt   = o_rmark_r;

    cmd.op        = CO_HOLD;
    cmd.phase     = step_r[0];
    head_in_value = key_r;
    head_in_mark  = 1'b0;
    head_in_occ   = 1'b1;     // never a hole in front of cell 0
    tail_in_value = head_value;
    tail_in_mark  = head_mark | hit;
    tail_in_occ   = head_occ;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          opc_nxt       = opcode_t'(in_ch.opcode);
          key_nxt       = VALUE_W'(in_ch.value);
          pos_nxt       = in_ch.position;
          step_nxt      = '0;
          found_nxt     = 1'b0;
          compacted_nxt = 1'b0;
          rval_nxt      = '0;
          rmark_nxt     = 1'b0;
          status_nxt    = STAT_OK;
          state_nxt     = S_DONE;
          unique case (opcode_t'(in_ch.opcode))
            OP_INSERT: begin
              if (count_r == CW'(DEPTH)) status_nxt = STAT_FULL;
              else                       state_nxt  = S_PUSH;
            end
            OP_DELETE: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                status_nxt = STAT_NOT_FOUND;
                state_nxt  = S_SCAN;
              end
            end
            OP_READ: begin
              if (CMPW'(in_ch.position) < CMPW'(count_r) &&
                  CMPW'(in_ch.position) < CMPW'(DEPTH)) state_nxt  = S_SCAN;
              else                                     status_nxt = STAT_RANGE;
            end
            OP_NOP: ;
            default: ;
          endcase
        end
      end
      S_PUSH: begin
        cmd.op    = CO_PUSH;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        // full rotation: the row is back in order after DEPTH steps
        cmd.op   = CO_ROTATE;
        step_nxt = step_r + SW'(1);
        if (hit) begin
          found_nxt  = 1'b1;
          status_nxt = STAT_OK;
        end
        marked_nxt = marked_r + CW'(hit);
        if (opc_r == OP_READ && CMPW'(step_r) == CMPW'(pos_r)) begin
          rval_nxt  = VAL_W'(signed'(head_value));
          rmark_nxt = head_mark;
        end
        if (last_step) begin
          step_nxt = '0;
          if (opc_r == OP_DELETE && (marked_r + CW'(hit)) > (count_r >> 1))
            state_nxt = S_PURGE;
          else
            state_nxt = S_DONE;
        end
      end
      S_PURGE: begin
        cmd.op        = CO_PURGE;
        compacted_nxt = 1'b1;
        count_nxt     = count_r - marked_r;
        marked_nxt    = '0;
        step_nxt      = '0;
        state_nxt     = S_SORT;
      end
      S_SORT: begin
        cmd.op      = CO_SORT;
        tail_in_occ = 1'b0;   // nothing beyond the last cell
        step_nxt    = step_r + SW'(1);
        if (last_step) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_comp_nxt    = compacted_r;
          o_len_nxt     = LEN_W'(count_r);
          o_mark_nxt    = LEN_W'(marked_r);
          o_rval_nxt    = rval_r;
          o_rmark_nxt   = rmark_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      marked_r    <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      marked_r    <= marked_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opc_r       <= opc_nxt;
    key_r       <= key_nxt;
    pos_r       <= pos_nxt;
    step_r      <= step_nxt;
    status_r    <= status_nxt;
    compacted_r <= compacted_nxt;
    rval_r      <= rval_nxt;
    rmark_r     <= rmark_nxt;
    o_status_r  <= o_status_nxt;
    o_comp_r    <= o_comp_nxt;
    o_len_r     <= o_len_nxt;
    o_mark_r    <= o_mark_nxt;
    o_rval_r    <= o_rval_nxt;
    o_rmark_r   <= o_rmark_nxt;
  end

  ldl_chain #(
    .DEPTH   (DEPTH),
    .VALUE_W (VALUE_W)
  ) u_chain (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .head_in_value (head_in_value),
    .head_in_mark  (head_in_mark),
    .head_in_occ   (head_in_occ),
    .tail_in_value (tail_in_value),
    .tail_in_mark  (tail_in_mark),
    .tail_in_occ   (tail_in_occ),
    .head_value    (head_value),
    .head_mark     (head_mark),
    .head_occ      (head_occ)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = o_status_r;
  assign out_ch.compacted    = o_comp_r;
  assign out_ch.list_length  = o_len_r;
  assign out_ch.marked_count = o_mark_r;
  assign out_ch.read_value   = o_rval_r;
  assign out_ch.read_marked  = o_rmark_r;

endmodule
`default_nettype wire

>>> design/ldl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldl_checker: port-level checks
// Watches the result channel of the list table; bound to the top level.
// ----------------------------------------------------------------------------
module ldl_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [2:0]        status,
  input wire logic              compacted,
  input wire logic [4:0]        list_length,
  input wire logic [4:0]        marked_count,
  input wire logic signed [31:0] read_value,
  input wire logic              read_marked
);
  import ldl_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(compacted) && $stable(list_length) && $stable(marked_count) &&
      $stable(read_value) && $stable(read_marked))
    else $error("result word changed while stalled");

  a_comp_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && compacted |-> marked_count == 5'd0)
    else $error("marks left after compaction");

  a_comp_del: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && compacted |-> status == STAT_OK || status == STAT_NOT_FOUND)
    else $error("compaction outside a delete");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STAT_OK |-> read_value == 32'sd0 && !read_marked)
    else $error("read fields set on a failed command");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word after reset");

endmodule

bind lazy_deletion_list_table_top ldl_checker u_ldl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .compacted    (out_ch.compacted),
  .list_length  (out_ch.list_length),
  .marked_count (out_ch.marked_count),
  .read_value   (out_ch.read_value),
  .read_marked  (out_ch.read_marked)
);
`default_nettype wire

>>> sim/tb_lazy_deletion_list_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lazy_deletion_list_table_top: self-checking bench for the list table
// Sends insert, delete, read and no-op words with random idling on both
// channels. A scoreboard keeps its own copy of the list, works out every
// result word and compares the words that come back field by field.
// ----------------------------------------------------------------------------
module tb_lazy_deletion_list_table_top;
  import ldl_pkg::*;

  localparam int DEPTH         = DEPTH_DEF;
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_WORDS  = 1625;
  localparam int CALM_FROM     = 1480;  // no idling from here on
  localparam int HOLD_AT       = 400;   // receiver goes quiet for a long stretch
  localparam int DRAIN_AT      = 900;   // sender waits for every result
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int STALL_LIMIT   = 4000;

  typedef struct packed {
    status_t                 status;
    logic                    compacted;
    logic [LEN_W-1:0]        list_length;
    logic [LEN_W-1:0]        marked_count;
    logic signed [VAL_W-1:0] read_value;
    logic                    read_marked;
  } list_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: list image, queue of result words still owed, mismatch count
  // --------------------------------------------------------------------------
  class list_scoreboard;
    logic [VAL_W-1:0] cell_value [DEPTH];
    bit               cell_mark  [DEPTH];
    int unsigned      used;
    int unsigned      marked;
    list_result_t     awaited_results [$];
    int               mismatches;
    int               checked;
    int               compactions;
    int               op_seen [4];
    int               status_seen [8];

    function new();
      used        = 0;
      marked      = 0;
      mismatches  = 0;
      checked     = 0;
      compactions = 0;
      foreach (cell_mark[i]) cell_mark[i] = 1'b0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction

    // one command applied to the list image
    function list_result_t apply_list_op(opcode_t op, logic [VAL_W-1:0] val,
                                         logic [POS_W-1:0] pos);
      list_result_t r;
      bit           hit;
      int unsigned  keep;
      int           i;
      r        = '0;
      r.status = STAT_OK;
      case (op)
        OP_INSERT: begin
          if (used >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            for (i = used; i > 0; i--) begin
              cell_value[i] = cell_value[i-1];
              cell_mark[i]  = cell_mark[i-1];
            end
            cell_value[0] = val;
            cell_mark[0]  = 1'b0;
            used++;
          end
        end
        OP_DELETE: begin
          if (used == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            hit = 1'b0;
            for (i = 0; i < used && !hit; i++) begin
              if (!cell_mark[i] && cell_value[i] == val) begin
                cell_mark[i] = 1'b1;
                marked++;
                hit = 1'b1;
              end
            end
            r.status = hit ? STAT_OK : STAT_NOT_FOUND;
            // more than half marked: squeeze marked cells out, order kept
            if (marked > used / 2) begin
              keep = 0;
              for (i = 0; i < used; i++) begin
                if (!cell_mark[i]) begin
                  cell_value[keep] = cell_value[i];
                  keep++;
                end
              end
              foreach (cell_mark[j]) cell_mark[j] = 1'b0;
              used        = keep;
              marked      = 0;
              r.compacted = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (pos < used) begin
            r.read_value  = cell_value[pos];
            r.read_marked = cell_mark[pos];
          end else begin
            r.status = STAT_RANGE;
          end
        end
        default: ;
      endcase
      r.list_length  = used[LEN_W-1:0];
      r.marked_count = marked[LEN_W-1:0];
      return r;
    endfunction

    function void note_command(opcode_t op, logic [VAL_W-1:0] val,
                               logic [POS_W-1:0] pos);
      list_result_t want;
      want = apply_list_op(op, val, pos);
      awaited_results.push_back(want);
      op_seen[op]++;
      status_seen[want.status]++;
      if (want.compacted) compactions++;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("[%0t] word %0d: %s is %0h, expected %0h", $time, checked, what, got, want);
    endtask

    task check_result(list_result_t got);
      list_result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch("unrequested word, status", got.status, 0);
        return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
      if (got.compacted !== want.compacted)
        report_mismatch("compacted", got.compacted, want.compacted);
      if (got.list_length !== want.list_length)
        report_mismatch("list_length", got.list_length, want.list_length);
      if (got.marked_count !== want.marked_count)
        report_mismatch("marked_count", got.marked_count, want.marked_count);
      if (got.read_value !== want.read_value)
        report_mismatch("read_value", got.read_value, want.read_value);
      if (got.read_marked !== want.read_marked)
        report_mismatch("read_marked", got.read_marked, want.read_marked);
      checked++;
    endtask

    task finish_check();
      if (awaited_results.size() != 0)
        report_mismatch("words never returned, count", 0, awaited_results.size());
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block and channels
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  ldl_in_if  in_ch ();
  ldl_out_if out_ch ();

  lazy_deletion_list_table_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_scoreboard   sb;
  bit               hold_req;
  bit               calm;
  int               idle_cycles;
  logic [VAL_W-1:0] value_pool [8];

  initial clk = 1'b0;
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Monitor: note accepted commands before checking words of the same edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    list_result_t got;
    if (rst_n === 1'b1) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_command(opcode_t'(in_ch.opcode), in_ch.value, in_ch.position);
      if (out_ch.valid && out_ch.ready) begin
        got.status       = status_t'(out_ch.status);
        got.compacted    = out_ch.compacted;
        got.list_length  = out_ch.list_length;
        got.marked_count = out_ch.marked_count;
        got.read_value   = out_ch.read_value;
        got.read_marked  = out_ch.read_marked;
        sb.check_result(got);
      end
    end
  end

  // watchdog: cycles without a handshake on either channel
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d words owed",
                 idle_cycles, sb.outstanding());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, quiet stretches, one long hold-off
  // --------------------------------------------------------------------------
  initial begin : receiver
    int stall_pct;
    int cyc;
    int n;
    stall_pct = 0;
    cyc       = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, 11);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  // called at a rising edge; returns at the edge that takes the word
  task automatic send_word(opcode_t op, logic [VAL_W-1:0] val, logic [POS_W-1:0] pos);
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.value    <= val;
    in_ch.position <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic sender_gap(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // one edge first so the word taken at the calling edge is on the books
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // pool values make deletes hit often; the rest is plain random
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return value_pool[3'($urandom_range(0, 7))];
  endfunction

  // half the reads aim inside the list, the rest anywhere
  function automatic logic [POS_W-1:0] read_position();
    if ($urandom_range(0, 1) == 0 || sb.used == 0) return POS_W'($urandom_range(0, 15));
    return POS_W'($urandom_range(0, sb.used - 1));
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    int ins_pct;
    int gap_pct;
    int roll;
    sb       = new();
    hold_req = 1'b0;
    calm     = 1'b0;
    ins_pct  = 50;
    gap_pct  = 0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (i = 4; i < 8; i++) value_pool[i] = $urandom();
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_NOP;
    in_ch.value    <= '0;
    in_ch.position <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, no-op, value extremes, full table, marked read
    send_word(OP_DELETE, 32'h0000_0005, 4'd0);   // empty list
    send_word(OP_READ, 32'h0, 4'd0);             // out of range on empty
    send_word(OP_NOP, 32'hffff_ffff, 4'd15);
    send_word(OP_INSERT, 32'h8000_0000, 4'd0);
    send_word(OP_INSERT, 32'h7fff_ffff, 4'd15);
    send_word(OP_INSERT, 32'h0000_0000, 4'd0);
    send_word(OP_INSERT, 32'hffff_ffff, 4'd0);
    for (i = 4; i < DEPTH; i++) send_word(OP_INSERT, $urandom(), 4'd0);
    send_word(OP_INSERT, 32'h1234_5678, 4'd0);   // table full, dropped
    send_word(OP_READ, 32'h0, 4'd15);            // oldest entry, most negative
    send_word(OP_READ, 32'h0, 4'd0);
    send_word(OP_DELETE, 32'h1234_5678, 4'd0);   // most likely not found
    send_word(OP_DELETE, 32'h7fff_ffff, 4'd0);
    send_word(OP_READ, 32'h0, 4'd14);            // now carries its mark

    // random: insert/delete balance drifts per block so the list fills and
    // empties, with compactions along the way
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 40 == 0) begin
        ins_pct = $urandom_range(20, 75);
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 20;
          default: gap_pct = 50;
        endcase
        value_pool[3'($urandom_range(0, 7))] = $urandom();
      end
      if (i == CALM_FROM) calm = 1'b1;
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == DRAIN_AT) drain_results();
      if (!calm && $urandom_range(0, 99) < gap_pct) sender_gap($urandom_range(1, 11));
      roll = $urandom_range(0, 99);
      if (roll < 3)
        send_word(OP_NOP, $urandom(), POS_W'($urandom_range(0, 15)));
      else if (roll < 3 + ins_pct)
        send_word(OP_INSERT, pick_value(), POS_W'($urandom_range(0, 15)));
      else if (roll < 3 + ins_pct + (97 - ins_pct) * 6 / 10)
        send_word(OP_DELETE, pick_value(), POS_W'($urandom_range(0, 15)));
      else
        send_word(OP_READ, $urandom(), read_position());
    end
    in_ch.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.finish_check();

    $display("Covered %0d words: %0d insert, %0d delete, %0d read, %0d no-op; %0d checked",
             sb.op_seen[OP_INSERT] + sb.op_seen[OP_DELETE] + sb.op_seen[OP_READ] +
             sb.op_seen[OP_NOP], sb.op_seen[OP_INSERT], sb.op_seen[OP_DELETE],
             sb.op_seen[OP_READ], sb.op_seen[OP_NOP], sb.checked);
    $display("%0d compactions, %0d full, %0d not found, %0d empty, %0d out of range",
             sb.compactions, sb.status_seen[STAT_FULL], sb.status_seen[STAT_NOT_FOUND],
             sb.status_seen[STAT_EMPTY], sb.status_seen[STAT_RANGE]);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
